// ===== src/kvmm_pkg.sv =====
// kvmm_pkg: command and status codes, field widths and transaction structs
// for the key/value multimap table; no dependencies
package kvmm_pkg;

  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 5;
  localparam int PAIR_BITS  = KEY_BITS + VALUE_BITS;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_LIST   = 2'd3
  } kvmm_cmd_t;

  typedef enum logic [1:0] {
    ST_ENTRY   = 2'd0,
    ST_NONE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_REMOVED = 2'd3
  } kvmm_status_t;

  typedef struct packed {
    kvmm_cmd_t             command;
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_value;
  } kvmm_in_t;

  typedef struct packed {
    kvmm_status_t          status;
    logic [KEY_BITS-1:0]   out_key;
    logic [VALUE_BITS-1:0] out_value;
    logic [COUNT_BITS-1:0] removed_count;
    logic [COUNT_BITS-1:0] fill_level;
    logic                  last;
  } kvmm_out_t;

endpackage

// ===== src/kvmm_ram.sv =====
// kvmm_ram: pair storage, one write port and one read port, registered read data
// no dependencies
module kvmm_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/key_value_multimap_table.sv =====
// key_value_multimap_table: bounded ordered multimap of key/value pairs
// depends on kvmm_pkg and kvmm_ram
//
// usage: a command transaction is taken at a rising edge with start high and
// busy low. add appends a pair, remove deletes every pair with the key and
// compacts the rest in order, find reports matching pairs oldest first, list
// reports all pairs. every command gives one or more results, each shown on
// out_item for exactly one cycle with out_valid high; the final one has last
// set. the receiver cannot stall, so results are never held back.
// add (or add on a full table, or any command on an empty table) gives its
// single result the cycle after acceptance and busy stays low. remove, find
// and list sweep the held pairs through the pair memory, one read per cycle,
// so busy stays high through the sweep and a final flush state; results are
// registered behind the sweep and the final result comes as busy falls.
// reset (rst_n low, synchronous) empties the table and drops any command in
// progress; stored pairs are not cleared and need no clearing pass.
module key_value_multimap_table #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kvmm_pkg::kvmm_in_t  in_item,
  output logic              out_valid,
  output kvmm_pkg::kvmm_out_t out_item
);
  import kvmm_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t                 state_r, state_nxt;
  kvmm_cmd_t              cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       kept_r, kept_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic                   rd_last_r, rd_last_nxt;
  logic [PAIR_BITS-1:0]   pend_r, pend_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  kvmm_out_t              out_r, out_nxt;

  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [PAIR_BITS-1:0]   wdata;
  logic                   re;
  logic [PAIR_BITS-1:0]   rdata;
  logic [KEY_BITS-1:0]    rd_key;
  logic                   hit;

  kvmm_ram #(
    .DEPTH(ENTRIES),
    .AW   (IDX_W),
    .DW   (PAIR_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(rd_ptr_r[IDX_W-1:0]),
    .rdata(rdata)
  );

  assign rd_key = rdata[PAIR_BITS-1 -: KEY_BITS];
  assign hit    = (cmd_r == CMD_LIST) || (rd_key == key_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    kept_nxt      = kept_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = 1'b0;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.fill_level = COUNT_BITS'(count_r);
    we            = 1'b0;
    waddr         = count_r[IDX_W-1:0];
    wdata         = {in_item.in_key, in_item.in_value};
    re            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt      = in_item.command;
          key_nxt      = in_item.in_key;
          rd_ptr_nxt   = '0;
          kept_nxt     = '0;
          pend_vld_nxt = 1'b0;
          unique case (in_item.command)
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              out_nxt.last  = 1'b1;
              if (count_r >= CNT_W'(ENTRIES)) begin
                out_nxt.status = ST_FULL;
              end else begin
                we                 = 1'b1;
                count_nxt          = count_r + CNT_W'(1);
                out_nxt.status     = ST_ENTRY;
                out_nxt.out_key    = in_item.in_key;
                out_nxt.out_value  = in_item.in_value;
                out_nxt.fill_level = COUNT_BITS'(count_r + CNT_W'(1));
              end
            end
            CMD_REMOVE, CMD_FIND, CMD_LIST: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.last   = 1'b1;
                out_nxt.status = (in_item.command == CMD_REMOVE) ? ST_REMOVED : ST_NONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_ptr_r < count_r) begin
          re          = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + CNT_W'(1);
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (rd_ptr_r + CNT_W'(1)) == count_r;
        end
        if (rd_vld_r) begin
          if (cmd_r == CMD_REMOVE) begin
            if (rd_key != key_r) begin
              we       = 1'b1;
              waddr    = kept_r[IDX_W-1:0];
              wdata    = rdata;
              kept_nxt = kept_r + CNT_W'(1);
            end
          end else if (hit) begin
            if (pend_vld_r) begin
              out_valid_nxt     = 1'b1;
              out_nxt.status    = ST_ENTRY;
              out_nxt.out_key   = pend_r[PAIR_BITS-1 -: KEY_BITS];
              out_nxt.out_value = pend_r[VALUE_BITS-1:0];
            end
            pend_nxt     = rdata;
            pend_vld_nxt = 1'b1;
          end
          if (rd_last_r) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt.last  = 1'b1;
        if (cmd_r == CMD_REMOVE) begin
          count_nxt             = kept_r;
          out_nxt.status        = ST_REMOVED;
          out_nxt.removed_count = COUNT_BITS'(count_r - kept_r);
          out_nxt.fill_level    = COUNT_BITS'(kept_r);
        end else if (pend_vld_r) begin
          out_nxt.status    = ST_ENTRY;
          out_nxt.out_key   = pend_r[PAIR_BITS-1 -: KEY_BITS];
          out_nxt.out_value = pend_r[VALUE_BITS-1:0];
        end else begin
          out_nxt.status = ST_NONE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    kept_r   <= kept_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== src/kvmm_checker.sv =====
// kvmm_checker: port-level checks on the multimap table, bound to the top level
// depends on kvmm_pkg and key_value_multimap_table
module kvmm_checker #(
  parameter int ENTRIES = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input kvmm_pkg::kvmm_in_t  in_item,
  input logic                out_valid,
  input kvmm_pkg::kvmm_out_t out_item
);
  import kvmm_pkg::*;

  // an add transaction always answers in the next cycle with its only result
  a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command == CMD_ADD) |=> (out_valid && out_item.last && !busy))
    else $error("add did not give a single result in the next cycle");

  // final result of a command coincides with the block going idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy)
    else $error("final result while still busy");

  // intermediate results only come from a sweep in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> (busy && out_item.status == ST_ENTRY))
    else $error("non-final result outside a sweep");

  // a full report means the table holds every entry
  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |->
      (out_item.fill_level == COUNT_BITS'(ENTRIES) && out_item.out_key == '0))
    else $error("full report with wrong fill level");

  // a sweep command is always answered before the next one is taken
  a_sweep_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command != CMD_ADD) |=> (busy || (out_valid && out_item.last)))
    else $error("sweep command left without an answer");

endmodule

bind key_value_multimap_table kvmm_checker #(.ENTRIES(ENTRIES)) u_kvmm_checker (.*);
